// ----- hw/rtl/iort_pkg.sv -----
// iort_pkg: shared types and constants of the i/o region table
// used by the compare unit, the sequencer and the top level
package iort_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);

  localparam logic [32:0] PORT_LIMIT = 33'h0_0001_0000;
  localparam logic [31:0] ID_FIRST = 32'd1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_ACQUIRE  = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_DESTROY  = 2'd3
  } op_t;

  localparam logic KIND_PORT = 1'b0;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY        = 4'd1,
    ST_BAD_TYPE     = 4'd2,
    ST_PORT_OVERRUN = 4'd3,
    ST_OVERLAP      = 4'd4,
    ST_FULL         = 4'd5,
    ST_UNKNOWN      = 4'd6,
    ST_ALREADY      = 4'd7,
    ST_NOT_ACQ      = 4'd8,
    ST_STILL        = 4'd9
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic clash;
    logic id_match;
  } cmp_res_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] id;
  } res_t;

endpackage

// ----- hw/rtl/iort_in_if.sv -----
// iort_in_if: request channel of the i/o region table, valid/ready with request fields
// no dependencies
interface iort_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  region_type;
  logic [31:0] region_base;
  logic [31:0] region_size;
  logic [31:0] target_id;

  modport source (
    output valid, opcode, region_type, region_base, region_size, target_id,
    input  ready
  );
  modport sink (
    input  valid, opcode, region_type, region_base, region_size, target_id,
    output ready
  );
endinterface

// ----- hw/rtl/iort_out_if.sv -----
// iort_out_if: response channel of the i/o region table, valid/ready with status and id
// no dependencies
interface iort_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] assigned_id;

  modport source (
    output valid, status, assigned_id,
    input  ready
  );
  modport sink (
    input  valid, status, assigned_id,
    output ready
  );
endinterface

// ----- hw/rtl/iort_ram.sv -----
// iort_ram: generic single write port, single read port ram with registered read
// no dependencies
module iort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/iort_cmp.sv -----
// iort_cmp: shared compare unit, checks one table entry against the current request
// depends on iort_pkg
module iort_cmp (
  input  iort_pkg::entry_t   ent,
  input  logic               kind,
  input  logic [31:0]        base,
  input  logic [32:0]        req_end,
  input  logic [31:0]        id,
  output iort_pkg::cmp_res_t res
);

  logic [32:0] ent_end;

  // ends are one bit wider so they never wrap
  assign ent_end = {1'b0, ent.base} + {1'b0, ent.len};

  assign res.clash = (ent.kind == kind) && ({1'b0, base} < ent_end)
                     && ({1'b0, ent.base} < req_end);
  assign res.id_match = (ent.ident == id);

endmodule

// ----- hw/rtl/iort_seq.sv -----
// iort_seq: sequencer of the i/o region table, scans one slot per cycle through the compare unit
// depends on iort_pkg, iort_in_if and iort_cmp
module iort_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  iort_in_if.sink                 in_ch,
  output iort_pkg::ram_req_t      ram_req,
  input  iort_pkg::entry_t        ram_rdata,
  output iort_pkg::res_t          res,
  input  logic                    res_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_t;

  state_t                       state_r, state_nxt;
  iort_pkg::op_t                op_r, op_nxt;
  logic [1:0]                   type_r, type_nxt;
  logic [31:0]                  base_r, base_nxt;
  logic [31:0]                  size_r, size_nxt;
  logic [31:0]                  id_r, id_nxt;
  logic [32:0]                  end_r, end_nxt;
  logic [iort_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         issued_r, issued_nxt;
  logic                         pvld_r, pvld_nxt;
  logic [iort_pkg::IDX_W-1:0]   pidx_r, pidx_nxt;
  logic                         found_r, found_nxt;
  logic [iort_pkg::IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic                         free_r, free_nxt;
  logic [iort_pkg::IDX_W-1:0]   free_idx_r, free_idx_nxt;
  iort_pkg::status_t            status_r, status_nxt;
  logic [31:0]                  assigned_r, assigned_nxt;
  logic [iort_pkg::SLOTS-1:0]   used_r, used_nxt;
  logic [iort_pkg::SLOTS-1:0]   acq_r, acq_nxt;
  logic [31:0]                  next_id_r, next_id_nxt;

  iort_pkg::cmp_res_t           cmp;
  logic [32:0]                  sum;
  logic                         slot_used;

  iort_cmp u_cmp (
    .ent     (ram_rdata),
    .kind    (type_r[0]),
    .base    (base_r),
    .req_end (end_r),
    .id      (id_r),
    .res     (cmp)
  );

  assign sum       = {1'b0, base_r} + {1'b0, size_r};
  assign slot_used = used_r[pidx_r];

  assign in_ch.ready = (state_r == S_IDLE);

  assign res.valid  = (state_r == S_RESP);
  assign res.status = status_r;
  assign res.id     = assigned_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    type_nxt      = type_r;
    base_nxt      = base_r;
    size_nxt      = size_r;
    id_nxt        = id_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    issued_nxt    = issued_r;
    pvld_nxt      = 1'b0;
    pidx_nxt      = idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    status_nxt    = status_r;
    assigned_nxt  = assigned_r;
    used_nxt      = used_r;
    acq_nxt       = acq_r;
    next_id_nxt   = next_id_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = free_idx_r;
    ram_req.wdata = '{kind: type_r[0], base: base_r, len: size_r, ident: next_id_r};
    ram_req.raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = iort_pkg::op_t'(in_ch.opcode);
          type_nxt  = in_ch.region_type;
          base_nxt  = in_ch.region_base;
          size_nxt  = in_ch.region_size;
          id_nxt    = in_ch.target_id;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        end_nxt      = sum;
        idx_nxt      = '0;
        issued_nxt   = 1'b0;
        found_nxt    = 1'b0;
        free_nxt     = 1'b0;
        assigned_nxt = '0;
        state_nxt    = S_SCAN;
        if (op_r == iort_pkg::OP_REGISTER) begin
          if (size_r == '0) begin
            status_nxt = iort_pkg::ST_EMPTY;
            state_nxt  = S_RESP;
          end else if (type_r[1]) begin
            status_nxt = iort_pkg::ST_BAD_TYPE;
            state_nxt  = S_RESP;
          end else if (type_r[0] == iort_pkg::KIND_PORT && sum > iort_pkg::PORT_LIMIT) begin
            status_nxt = iort_pkg::ST_PORT_OVERRUN;
            state_nxt  = S_RESP;
          end
        end
      end
      S_SCAN: begin
        // issue side: one ram read per cycle
        if (!issued_r) begin
          pvld_nxt = 1'b1;
          if (idx_r == iort_pkg::SLOT_LAST) begin
            issued_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // compare side: entry read in the previous cycle
        if (pvld_r) begin
          if (pidx_r == iort_pkg::SLOT_LAST) begin
            state_nxt = S_APPLY;
          end
          if (op_r == iort_pkg::OP_REGISTER) begin
            if (!slot_used && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pidx_r;
            end
            if (slot_used && cmp.clash) begin
              status_nxt = iort_pkg::ST_OVERLAP;
              state_nxt  = S_RESP;
            end
          end else if (slot_used && cmp.id_match) begin
            found_nxt     = 1'b1;
            found_idx_nxt = pidx_r;
            state_nxt     = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        state_nxt = S_RESP;
        unique case (op_r)
          iort_pkg::OP_REGISTER: begin
            if (!free_r) begin
              status_nxt = iort_pkg::ST_FULL;
            end else begin
              ram_req.we           = 1'b1;
              used_nxt[free_idx_r] = 1'b1;
              acq_nxt[free_idx_r]  = 1'b0;
              assigned_nxt         = next_id_r;
              next_id_nxt          = next_id_r + 32'd1;
              status_nxt           = iort_pkg::ST_OK;
            end
          end
          iort_pkg::OP_ACQUIRE: begin
            if (!found_r) begin
              status_nxt = iort_pkg::ST_UNKNOWN;
            end else if (acq_r[found_idx_r]) begin
              status_nxt = iort_pkg::ST_ALREADY;
            end else begin
              acq_nxt[found_idx_r] = 1'b1;
              status_nxt           = iort_pkg::ST_OK;
            end
          end
          iort_pkg::OP_RELEASE: begin
            if (!found_r || !acq_r[found_idx_r]) begin
              status_nxt = iort_pkg::ST_NOT_ACQ;
            end else begin
              acq_nxt[found_idx_r] = 1'b0;
              status_nxt           = iort_pkg::ST_OK;
            end
          end
          iort_pkg::OP_DESTROY: begin
            if (!found_r) begin
              status_nxt = iort_pkg::ST_UNKNOWN;
            end else if (acq_r[found_idx_r]) begin
              status_nxt = iort_pkg::ST_STILL;
            end else begin
              used_nxt[found_idx_r] = 1'b0;
              acq_nxt[found_idx_r]  = 1'b0;
              status_nxt            = iort_pkg::ST_OK;
            end
          end
          default: begin
            status_nxt = iort_pkg::ST_UNKNOWN;
          end
        endcase
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    type_r      <= type_nxt;
    base_r      <= base_nxt;
    size_r      <= size_nxt;
    id_r        <= id_nxt;
    end_r       <= end_nxt;
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    status_r    <= status_nxt;
    assigned_r  <= assigned_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      issued_r  <= 1'b0;
      pvld_r    <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      used_r    <= '0;
      acq_r     <= '0;
      next_id_r <= iort_pkg::ID_FIRST;
    end else begin
      state_r   <= state_nxt;
      issued_r  <= issued_nxt;
      pvld_r    <= pvld_nxt;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
      used_r    <= used_nxt;
      acq_r     <= acq_nxt;
      next_id_r <= next_id_nxt;
    end
  end

endmodule

// ----- hw/rtl/io_region_table_top.sv -----
// io_region_table_top: top level of the i/o region table
// depends on iort_pkg, iort_in_if, iort_out_if, iort_ram and iort_seq
//
// usage
//   in_ch carries one request per transaction: register, acquire, release or destroy,
//   with region type, base, size and target id. out_ch returns exactly one transaction
//   per request: a status code and the id handed out by a successful register.
//   requests are handled one at a time; in_ch.ready is high only while the sequencer
//   is idle. a request is latched, then put through the up-front checks
//   (empty, bad type, port overrun), then a scan of the slot ram at one slot per cycle
//   (cut short at an overlap or at the first id match), then the table is updated and
//   the result is passed to the output register. an early reject skips the scan and
//   the update. the scan goes through the single read port of the slot ram.
//   reset clears all used and acquired marks and sets the next id to 1; the slot
//   ram itself needs no clearing since only used slots are ever looked at.
//   a stalled out_ch holds the result in the output register; the sequencer then
//   waits with its own result until the register frees up.
module io_region_table_top (
  input  logic      clk,
  input  logic      rst_n,
  iort_in_if.sink   in_ch,
  iort_out_if.source out_ch
);

  iort_pkg::ram_req_t ram_req;
  iort_pkg::entry_t   ram_rdata;
  iort_pkg::res_t     res;
  logic               res_ready;

  logic               out_valid_r, out_valid_nxt;
  iort_pkg::status_t  out_status_r, out_status_nxt;
  logic [31:0]        out_id_r, out_id_nxt;

  iort_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  iort_ram #(
    .WIDTH (iort_pkg::ENTRY_W),
    .DEPTH (iort_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    if (res.valid && res_ready) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
      out_id_nxt     = res.id;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.assigned_id = out_id_r;

endmodule

// ----- bench/io_region_table_top_tb.sv -----
// io_region_table_top_tb: self-checking bench for the i/o region table
// runs a directed and a random request mix against a behavioural table and compares every reply
// depends on iort_pkg, iort_in_if, iort_out_if and io_region_table_top
`timescale 1ns / 1ps

module io_region_table_top_tb;

  localparam logic [1:0] TYPE_PORT  = 2'd0;
  localparam logic [1:0] TYPE_MMIO  = 2'd1;
  localparam logic [1:0] TYPE_BAD_A = 2'd2;
  localparam logic [1:0] TYPE_BAD_B = 2'd3;
  localparam int RANDOM_REQUESTS = 1400;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  rtype;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] id;
  } region_req_t;

  typedef struct packed {
    iort_pkg::status_t status;
    logic [31:0]       id;
  } region_resp_t;

  typedef struct packed {
    logic [iort_pkg::SLOTS-1:0]       used;
    logic [iort_pkg::SLOTS-1:0]       held;
    logic [iort_pkg::SLOTS-1:0]       kind;
    logic [iort_pkg::SLOTS-1:0][31:0] base;
    logic [iort_pkg::SLOTS-1:0][31:0] len;
    logic [iort_pkg::SLOTS-1:0][31:0] ident;
    logic [31:0]                      next_id;
  } region_table_t;

  logic clk;
  logic rst_n;

  iort_in_if  in_ch ();
  iort_out_if out_ch ();

  io_region_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  region_req_t   request_q[$];
  region_resp_t  reply_q[$];
  region_table_t plan_table;
  region_table_t live_table;
  region_req_t   seen_req;
  region_req_t   next_req;
  region_resp_t  predicted;
  region_resp_t  wanted;
  int unsigned   n_accepted;
  int unsigned   n_planned;
  int unsigned   n_replies;
  int unsigned   n_errors;
  int unsigned   status_count[16];
  int            send_idle;
  int            stall_left;
  logic          hold_out;

  function automatic region_table_t table_step(input region_table_t t, input region_req_t r,
                                               output region_resp_t o);
    logic [32:0] req_end;
    logic [32:0] slot_end;
    logic        clash;
    int          free_idx;
    int          hit;
    o.status = iort_pkg::ST_OK;
    o.id = '0;
    if (r.op == iort_pkg::OP_REGISTER) begin
      req_end = {1'b0, r.base} + {1'b0, r.len};
      clash = 1'b0;
      free_idx = -1;
      for (int i = iort_pkg::SLOTS - 1; i >= 0; i--) begin
        slot_end = {1'b0, t.base[i]} + {1'b0, t.len[i]};
        if (t.used[i] && t.kind[i] == r.rtype[0] && {1'b0, r.base} < slot_end &&
            {1'b0, t.base[i]} < req_end)
          clash = 1'b1;
        if (!t.used[i])
          free_idx = i;
      end
      if (r.len == '0)
        o.status = iort_pkg::ST_EMPTY;
      else if (r.rtype > TYPE_MMIO)
        o.status = iort_pkg::ST_BAD_TYPE;
      else if (r.rtype == TYPE_PORT && req_end > iort_pkg::PORT_LIMIT)
        o.status = iort_pkg::ST_PORT_OVERRUN;
      else if (clash)
        o.status = iort_pkg::ST_OVERLAP;
      else if (free_idx < 0)
        o.status = iort_pkg::ST_FULL;
      else begin
        t.used[free_idx] = 1'b1;
        t.held[free_idx] = 1'b0;
        t.kind[free_idx] = r.rtype[0];
        t.base[free_idx] = r.base;
        t.len[free_idx] = r.len;
        t.ident[free_idx] = t.next_id;
        o.id = t.next_id;
        t.next_id = t.next_id + 32'd1;
      end
    end else begin
      hit = -1;
      for (int i = iort_pkg::SLOTS - 1; i >= 0; i--)
        if (t.used[i] && t.ident[i] == r.id)
          hit = i;
      case (r.op)
        iort_pkg::OP_ACQUIRE: begin
          if (hit < 0)
            o.status = iort_pkg::ST_UNKNOWN;
          else if (t.held[hit])
            o.status = iort_pkg::ST_ALREADY;
          else
            t.held[hit] = 1'b1;
        end
        iort_pkg::OP_RELEASE: begin
          if (hit < 0 || !t.held[hit])
            o.status = iort_pkg::ST_NOT_ACQ;
          else
            t.held[hit] = 1'b0;
        end
        default: begin
          if (hit < 0)
            o.status = iort_pkg::ST_UNKNOWN;
          else if (t.held[hit])
            o.status = iort_pkg::ST_STILL;
          else begin
            t.used[hit] = 1'b0;
            t.held[hit] = 1'b0;
            t.kind[hit] = 1'b0;
            t.base[hit] = '0;
            t.len[hit] = '0;
            t.ident[hit] = '0;
          end
        end
      endcase
    end
    return t;
  endfunction

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if ((n_accepted / 150) % 4 == 2)
      return 0;
    if (roll < 55)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_request(input iort_pkg::op_t op, input logic [1:0] rtype,
                             input logic [31:0] base, input logic [31:0] len,
                             input logic [31:0] id);
    region_req_t  r;
    region_resp_t ignored;
    r.op = op;
    r.rtype = rtype;
    r.base = base;
    r.len = len;
    r.id = id;
    request_q.push_back(r);
    plan_table = table_step(plan_table, r, ignored);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // request driver, prediction at the accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0;
      in_ch.region_type <= '0;
      in_ch.region_base <= '0;
      in_ch.region_size <= '0;
      in_ch.target_id <= '0;
      send_idle <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        seen_req.op = in_ch.opcode;
        seen_req.rtype = in_ch.region_type;
        seen_req.base = in_ch.region_base;
        seen_req.len = in_ch.region_size;
        seen_req.id = in_ch.target_id;
        live_table = table_step(live_table, seen_req, predicted);
        reply_q.push_back(predicted);
        n_accepted++;
      end
      if (send_idle != 0) begin
        in_ch.valid <= 1'b0;
        send_idle <= send_idle - 1;
      end else if (request_q.size() != 0) begin
        next_req = request_q.pop_front();
        in_ch.opcode <= next_req.op;
        in_ch.region_type <= next_req.rtype;
        in_ch.region_base <= next_req.base;
        in_ch.region_size <= next_req.len;
        in_ch.target_id <= next_req.id;
        in_ch.valid <= 1'b1;
        send_idle <= pick_pause();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // reply side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_out) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((out_ch.valid && out_ch.ready) || $urandom_range(0, 7) == 0) begin
      int gap;
      gap = pick_pause();
      if (gap == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left <= gap - 1;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_replies++;
      status_count[out_ch.status]++;
      if (reply_q.size() == 0) begin
        $display("%0t: reply with nothing outstanding, status %0d id %0d", $time,
                 out_ch.status, out_ch.assigned_id);
        n_errors++;
      end else begin
        wanted = reply_q.pop_front();
        if (out_ch.status !== wanted.status) begin
          $display("%0t: status expected %0d got %0d", $time, wanted.status, out_ch.status);
          n_errors++;
        end
        if (out_ch.assigned_id !== wanted.id) begin
          $display("%0t: assigned id expected %0d got %0d", $time, wanted.id,
                   out_ch.assigned_id);
          n_errors++;
        end
      end
    end
  end

  // long receiver hold so the table backs up into the request side
  initial begin
    hold_out = 1'b0;
    for (int k = 0; k < 2; k++) begin
      while (n_accepted < 300 + k * 600)
        @(posedge clk);
      hold_out <= 1'b1;
      repeat (400) @(posedge clk);
      hold_out <= 1'b0;
    end
  end

  initial begin
    int unsigned    roll;
    int unsigned    reg_pct;
    int             used_idx[$];
    int             s;
    iort_pkg::op_t  op;
    logic [1:0]     rtype;
    logic [31:0]    base;
    logic [31:0]    len;
    logic [31:0]    target;

    rst_n = 1'b0;
    n_accepted = 0;
    n_replies = 0;
    n_errors = 0;
    foreach (status_count[i])
      status_count[i] = 0;
    plan_table = '0;
    plan_table.next_id = iort_pkg::ID_FIRST;
    live_table = '0;
    live_table.next_id = iort_pkg::ID_FIRST;

    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'h0, 32'h0, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_BAD_A, 32'h100, 32'h10, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_BAD_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'hFFF0, 32'h20, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'hFF00, 32'h100, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'h0, 32'h10, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'h8, 32'h8, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_MMIO, 32'h0, 32'h10, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_MMIO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_MMIO, 32'h10, 32'h1, 32'h0);
    add_request(iort_pkg::OP_REGISTER, TYPE_MMIO, 32'hFFFF_FFF0, 32'h10, 32'h0);
    add_request(iort_pkg::OP_ACQUIRE, TYPE_PORT, 32'h0, 32'h0, 32'h0);
    add_request(iort_pkg::OP_ACQUIRE, TYPE_PORT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    add_request(iort_pkg::OP_ACQUIRE, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_ACQUIRE, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_DESTROY, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_RELEASE, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_RELEASE, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_RELEASE, TYPE_PORT, 32'h0, 32'h0, 32'd99);
    add_request(iort_pkg::OP_DESTROY, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_DESTROY, TYPE_PORT, 32'h0, 32'h0, 32'd2);
    add_request(iort_pkg::OP_REGISTER, TYPE_PORT, 32'h0, 32'h10, 32'h0);
    add_request(iort_pkg::OP_ACQUIRE, TYPE_PORT, 32'h0, 32'h0, 32'd6);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      used_idx.delete();
      for (int i = 0; i < iort_pkg::SLOTS; i++)
        if (plan_table.used[i])
          used_idx.push_back(i);
      // one stretch in three is fill-heavy, the others lookup-heavy, so the table runs full now and then
      reg_pct = ((n / 150) % 3 == 0) ? 70 : 30;
      roll = $urandom_range(0, 99);
      if (roll < reg_pct) begin
        op = iort_pkg::OP_REGISTER;
        target = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          rtype = 2'($urandom_range(0, 3));
          base = $urandom;
          len = '0;
        end else if (roll < 10) begin
          rtype = 2'($urandom_range(2, 3));
          base = $urandom;
          len = $urandom;
        end else if (roll < 40) begin
          rtype = TYPE_PORT;
          base = $urandom_range(0, 16'hFFFF);
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'h2_0000)
                                            : $urandom_range(1, 256);
        end else if (roll < 55 && used_idx.size() != 0) begin
          s = used_idx[$urandom_range(0, used_idx.size() - 1)];
          rtype = {1'b0, plan_table.kind[s]};
          base = plan_table.base[s] + $urandom_range(0, 3);
          len = $urandom_range(1, 64);
        end else begin
          rtype = TYPE_MMIO;
          base = $urandom;
          len = (roll < 60) ? $urandom : $urandom_range(1, 4096);
        end
      end else begin
        op = iort_pkg::op_t'($urandom_range(1, 3));
        rtype = 2'($urandom_range(0, 3));
        base = $urandom;
        len = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 75 && used_idx.size() != 0)
          target = plan_table.ident[used_idx[$urandom_range(0, used_idx.size() - 1)]];
        else if (roll < 90)
          target = plan_table.next_id - $urandom_range(0, 6);
        else
          target = $urandom;
      end
      add_request(op, rtype, base, len, target);
    end
    n_planned = request_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_planned)
      @(posedge clk);
    while (reply_q.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d requests, %0d replies: %0d ok, %0d empty, %0d bad type, %0d overrun",
             n_accepted, n_replies, status_count[iort_pkg::ST_OK],
             status_count[iort_pkg::ST_EMPTY], status_count[iort_pkg::ST_BAD_TYPE],
             status_count[iort_pkg::ST_PORT_OVERRUN]);
    $display("%0d overlap, %0d full, %0d unknown id, %0d held, %0d not held, %0d still held",
             status_count[iort_pkg::ST_OVERLAP], status_count[iort_pkg::ST_FULL],
             status_count[iort_pkg::ST_UNKNOWN], status_count[iort_pkg::ST_ALREADY],
             status_count[iort_pkg::ST_NOT_ACQ], status_count[iort_pkg::ST_STILL]);
    if (n_errors == 0 && reply_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
